>>> rtl/ntc_adc_to_temperature_macros.svh
// ----------------------------------------------------------------------------
// ntc_adc_to_temperature assertion macros
// concurrent checks that compile away in synthesis
// ----------------------------------------------------------------------------
`ifndef NTC_ADC_TO_TEMPERATURE_MACROS_SVH
`define NTC_ADC_TO_TEMPERATURE_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define NTC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ntc assertion failed");
// condition must never be seen outside reset
`define NTC_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("ntc forbidden condition seen");
`else
`define NTC_ASSERT(lbl, clk, rst_n, prop)
`define NTC_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

>>> rtl/ntc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntc_pkg
// shared types, widths and constants of the ntc temperature converter
// ----------------------------------------------------------------------------
package ntc_pkg;

  // default converter full scale
  localparam int unsigned ADC_FULL_SCALE = 4096;

  // field and register widths
  localparam int unsigned CODE_W     = 12;
  localparam int unsigned TEMP_W     = 18;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned BETA_W     = 14;
  localparam int unsigned OHMS_W     = 20;
  localparam int unsigned T0_W       = 9;
  localparam int unsigned OFFS_W     = 15;

  // fixed point formats
  localparam int unsigned FRAC_W  = 24;   // log2 fraction bits
  localparam int unsigned MANT_W  = 32;   // log2 mantissa bits
  localparam int unsigned LN2_W   = 30;
  localparam int unsigned TK_W    = 18;   // quotient bits kept before saturation
  localparam int unsigned RES_W   = 20;   // signed celsius before saturation
  localparam int unsigned HUND_W  = 7;    // width of the factor 100

  localparam logic [LN2_W-1:0]  LN2_Q30 = 30'd744261118;
  localparam logic [HUND_W-1:0] HUNDRED = 7'd100;

  localparam logic signed [RES_W-1:0] OUT_MAX       = 20'sd80000;
  localparam logic signed [RES_W-1:0] OUT_MIN       = -20'sd30000;
  localparam logic signed [RES_W-1:0] CELSIUS_CENTI = 20'sd27300;

  // register reset values
  localparam logic [BETA_W-1:0]        RST_BETA   = 14'd4030;
  localparam logic [OHMS_W-1:0]        RST_SERIES = 20'd10000;
  localparam logic [OHMS_W-1:0]        RST_REF    = 20'd10000;
  localparam logic [T0_W-1:0]          RST_T0     = 9'd298;
  localparam logic signed [OFFS_W-1:0] RST_OFFSET = -15'sd500;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_FULL = 2'd2,
    ST_SAT  = 2'd3
  } status_e;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BETA       = 3'd0,
    CFG_SERIES     = 3'd1,
    CFG_REF_OHMS   = 3'd2,
    CFG_REF_KELVIN = 3'd3,
    CFG_OFFSET     = 3'd4
  } cfg_idx_e;

  // control that travels with each transaction through the pipeline
  typedef struct packed {
    logic    vld;
    status_e st;
    logic    hot;
  } side_t;

  // channel payloads
  typedef struct packed {
    logic [CODE_W-1:0] adc_code;
  } in_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature_centi;
    logic [STATUS_W-1:0]      status;
  } out_t;

endpackage

>>> rtl/ntc_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntc_stream_if
// valid/ready channel carrying one payload per transaction
// ----------------------------------------------------------------------------
interface ntc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/ntc_log2.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntc_log2
// two-lane pipelined log2 in Q24, one fraction bit per stage
// ----------------------------------------------------------------------------
module ntc_log2 #(
  parameter  int unsigned X_W = 37,
  localparam int unsigned N_W = $clog2(X_W),
  localparam int unsigned L_W = N_W + ntc_pkg::FRAC_W
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  ntc_pkg::side_t      side_i,
  input  logic [X_W-1:0]      x_i [2],
  output ntc_pkg::side_t      side_o,
  output logic [L_W-1:0]      log_o [2]
);

  localparam int unsigned ITER   = ntc_pkg::FRAC_W;
  localparam int unsigned MANT_W = ntc_pkg::MANT_W;
  localparam int unsigned FRAC_W = ntc_pkg::FRAC_W;
  localparam int unsigned LAT    = ITER + 2;

  ntc_pkg::side_t side_q [LAT];

  // control pipeline: leading-one stage, normalize stage, one per fraction bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LAT; i++) side_q[i] <= '0;
    end else if (en_i) begin
      side_q[0] <= side_i;
      for (int i = 1; i < LAT; i++) side_q[i] <= side_q[i-1];
    end
  end

  assign side_o = side_q[LAT-1];

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [X_W-1:0]      x_q;
    logic [N_W-1:0]      msb_d;
    logic [N_W-1:0]      na_q;
    logic [X_W-1:0]      norm_d;
    logic [MANT_W-1:0]   y_q  [ITER+1];
    logic [FRAC_W-1:0]   f_q  [ITER+1];
    logic [N_W-1:0]      n_q  [ITER+1];
    logic [2*MANT_W-1:0] sq_d [ITER];
    logic [MANT_W:0]     sh_d [ITER];
    logic [MANT_W-1:0]   y_d  [ITER];
    logic [FRAC_W-1:0]   f_d  [ITER];

    // leading one, normalization and squaring steps
    always_comb begin
      msb_d = '0;
      for (int i = 0; i < X_W; i++) begin
        if (x_i[l][i]) msb_d = N_W'(i);
      end
      norm_d = x_q << (N_W'(X_W - 1) - na_q);
      for (int j = 0; j < ITER; j++) begin
        sq_d[j] = y_q[j] * y_q[j];
        sh_d[j] = sq_d[j][2*MANT_W-1:MANT_W-1];
        y_d[j]  = sh_d[j][MANT_W] ? sh_d[j][MANT_W:1] : sh_d[j][MANT_W-1:0];
        f_d[j]  = {f_q[j][FRAC_W-2:0], sh_d[j][MANT_W]};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q    <= x_i[l];
        na_q   <= msb_d;
        y_q[0] <= norm_d[X_W-1 -: MANT_W];
        f_q[0] <= '0;
        n_q[0] <= na_q;
        for (int j = 0; j < ITER; j++) begin
          y_q[j+1] <= y_d[j];
          f_q[j+1] <= f_d[j];
          n_q[j+1] <= n_q[j];
        end
      end
    end

    assign log_o[l] = {n_q[ITER], f_q[ITER]};
  end

endmodule

>>> rtl/ntc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntc_div
// pipelined restoring divider, one quotient bit per stage, with overflow flag
// ----------------------------------------------------------------------------
module ntc_div #(
  parameter int unsigned NP_W  = 55,
  parameter int unsigned DEN_W = 40,
  parameter int unsigned Q_W   = 18
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  ntc_pkg::side_t     side_i,
  input  logic [NP_W-1:0]    num_i,
  input  logic [DEN_W-1:0]   den_i,
  output ntc_pkg::side_t     side_o,
  output logic [Q_W-1:0]     quo_o,
  output logic               ovf_o
);

  localparam int unsigned R_W = (DEN_W + Q_W > NP_W) ? DEN_W + Q_W : NP_W;

  ntc_pkg::side_t   side_q [Q_W+1];
  logic [R_W-1:0]   rem_q  [Q_W+1];
  logic [DEN_W-1:0] den_q  [Q_W+1];
  logic [Q_W-1:0]   quo_q  [Q_W+1];
  logic             ovf_q  [Q_W+1];
  logic             ovf_d;
  logic [R_W-1:0]   cand_d [Q_W];
  logic             ge_d   [Q_W];
  logic [R_W-1:0]   rem_d  [Q_W];

  // quotient would not fit in Q_W bits
  assign ovf_d = R_W'(num_i) >= (R_W'(den_i) << Q_W);

  // trial subtract, most significant quotient bit first
  always_comb begin
    for (int k = 0; k < Q_W; k++) begin
      cand_d[k] = R_W'(den_q[k]) << (Q_W - 1 - k);
      ge_d[k]   = rem_q[k] >= cand_d[k];
      rem_d[k]  = ge_d[k] ? rem_q[k] - cand_d[k] : rem_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= Q_W; k++) side_q[k] <= '0;
    end else if (en_i) begin
      side_q[0] <= side_i;
      for (int k = 1; k <= Q_W; k++) side_q[k] <= side_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= R_W'(num_i);
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      ovf_q[0] <= ovf_d;
      for (int k = 0; k < Q_W; k++) begin
        rem_q[k+1] <= rem_d[k];
        den_q[k+1] <= den_q[k];
        quo_q[k+1] <= {quo_q[k][Q_W-2:0], ge_d[k]};
        ovf_q[k+1] <= ovf_q[k];
      end
    end
  end

  assign side_o = side_q[Q_W];
  assign quo_o  = quo_q[Q_W];
  assign ovf_o  = ovf_q[Q_W];

endmodule

>>> rtl/ntc_adc_to_temperature.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntc_adc_to_temperature
// ntc thermistor adc code to temperature in hundredths of a degree celsius
// ----------------------------------------------------------------------------
// usage:
//   adc_i is a valid/ready sink carrying one 12-bit converter code per
//   transaction; temp_o is a valid/ready source carrying the temperature
//   (signed, 0.01 degC, saturated to -300.00..800.00) and a status code.
//   the user must write registers via cfg_we_i/cfg_idx_i/cfg_wdata_i only
//   while no transaction is in flight (unenforced); unknown indexes are dropped.
// path: from the accepting edge to output valid a transaction passes through
//   53 register stages: the resistance products, the 26-stage log2 unit,
//   five stages of log difference, ln scaling, denominator and numerator,
//   the 19-stage divider and the saturation and output registers.
// throughput: one transaction per cycle unless stalled; stages are registers.
// reset: all valid bits clear and the registers take their default values
//   (beta 4030 K, 10 kohm series and reference, 298 K, offset -5.00 K).
// stall: a result waiting on temp_o is held in the output register; the
//   pipeline keeps accepting and moving while its last stage is empty and
//   freezes as a whole only when that stage is also full.
// ----------------------------------------------------------------------------
`include "ntc_adc_to_temperature_macros.svh"

module ntc_adc_to_temperature #(
  parameter int unsigned ADC_FULL_SCALE = ntc_pkg::ADC_FULL_SCALE
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  ntc_stream_if.sink                       adc_i,
  ntc_stream_if.source                     temp_o,
  input  logic                             cfg_we_i,
  input  logic [ntc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ntc_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  localparam int unsigned CODE_W = ntc_pkg::CODE_W;
  localparam int unsigned OHMS_W = ntc_pkg::OHMS_W;
  localparam int unsigned BETA_W = ntc_pkg::BETA_W;
  localparam int unsigned T0_W   = ntc_pkg::T0_W;
  localparam int unsigned OFFS_W = ntc_pkg::OFFS_W;
  localparam int unsigned FRAC_W = ntc_pkg::FRAC_W;
  localparam int unsigned LN2_W  = ntc_pkg::LN2_W;
  localparam int unsigned TK_W   = ntc_pkg::TK_W;
  localparam int unsigned RES_W  = ntc_pkg::RES_W;
  localparam int unsigned TEMP_W = ntc_pkg::TEMP_W;

  localparam int unsigned FS_W   = $clog2(ADC_FULL_SCALE + 1);
  localparam int unsigned CF_W   = (FS_W > CODE_W) ? FS_W : CODE_W;
  localparam int unsigned A_W    = OHMS_W + CODE_W;
  localparam int unsigned B_W    = OHMS_W + FS_W;
  localparam int unsigned X_W    = (B_W > A_W) ? B_W : A_W;
  localparam int unsigned N_W    = $clog2(X_W);
  localparam int unsigned LQ_W   = N_W + FRAC_W;
  localparam int unsigned D_W    = LQ_W + 1;
  localparam int unsigned LP_W   = LQ_W + LN2_W;
  localparam int unsigned TL_W   = T0_W + LQ_W;
  localparam int unsigned BS_W   = BETA_W + FRAC_W;
  localparam int unsigned DEN_SW = ((BS_W > TL_W) ? BS_W : TL_W) + 2;
  localparam int unsigned DEN_W  = DEN_SW - 1;
  localparam int unsigned NUMC_W = BETA_W + T0_W + ntc_pkg::HUND_W;
  localparam int unsigned NUM_W  = NUMC_W + FRAC_W;
  localparam int unsigned NP_W   = ((NUM_W > DEN_W) ? NUM_W : DEN_W) + 1;

  localparam logic signed [TEMP_W-1:0] OUT_MAX_T = TEMP_W'(ntc_pkg::OUT_MAX);
  localparam logic signed [TEMP_W-1:0] OUT_MIN_T = TEMP_W'(ntc_pkg::OUT_MIN);

  // configuration registers
  logic [BETA_W-1:0]        beta_q;
  logic [OHMS_W-1:0]        series_q;
  logic [OHMS_W-1:0]        ref_q;
  logic [T0_W-1:0]          t0_q;
  logic signed [OFFS_W-1:0] offs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beta_q   <= ntc_pkg::RST_BETA;
      series_q <= ntc_pkg::RST_SERIES;
      ref_q    <= ntc_pkg::RST_REF;
      t0_q     <= ntc_pkg::RST_T0;
      offs_q   <= ntc_pkg::RST_OFFSET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ntc_pkg::CFG_BETA:       beta_q   <= cfg_wdata_i[BETA_W-1:0];
        ntc_pkg::CFG_SERIES:     series_q <= cfg_wdata_i[OHMS_W-1:0];
        ntc_pkg::CFG_REF_OHMS:   ref_q    <= cfg_wdata_i[OHMS_W-1:0];
        ntc_pkg::CFG_REF_KELVIN: t0_q     <= cfg_wdata_i[T0_W-1:0];
        ntc_pkg::CFG_OFFSET:     offs_q   <= signed'(cfg_wdata_i[OFFS_W-1:0]);
        default: ;
      endcase
    end
  end

  // numerator constant 100*beta*t0, follows the registers
  logic [BETA_W+T0_W-1:0] bt_q;
  logic [NUMC_W-1:0]      numc_q;

  always_ff @(posedge clk_i) begin
    bt_q   <= (BETA_W + T0_W)'(beta_q) * (BETA_W + T0_W)'(t0_q);
    numc_q <= NUMC_W'(bt_q) * NUMC_W'(ntc_pkg::HUNDRED);
  end

  // pipeline advance: stop only when the last stage and output are both full
  logic                 en;
  ntc_pkg::side_t       fin_side_q;
  logic                 out_vld_q;
  ntc_pkg::out_t        out_q;

  assign en          = !(fin_side_q.vld && out_vld_q && !temp_o.ready);
  assign adc_i.ready = en;

  // stage 0: special codes and divider resistances
  logic [CODE_W-1:0] code;
  ntc_pkg::side_t    s0_side_d, s0_side_q;
  logic [FS_W-1:0]   fs_minus;
  logic [A_W-1:0]    a_q;
  logic [B_W-1:0]    b_q;

  assign code     = adc_i.data.adc_code;
  assign fs_minus = FS_W'(ADC_FULL_SCALE) - FS_W'(code);

  always_comb begin
    s0_side_d     = '0;
    s0_side_d.vld = adc_i.valid;
    if (code == '0 || series_q == '0) begin
      s0_side_d.st = ntc_pkg::ST_ZERO;
    end else if (CF_W'(code) >= CF_W'(ADC_FULL_SCALE) || ref_q == '0) begin
      s0_side_d.st = ntc_pkg::ST_FULL;
    end else begin
      s0_side_d.st = ntc_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_side_q <= '0;
    end else if (en) begin
      s0_side_q <= s0_side_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q <= A_W'(series_q) * A_W'(code);
      b_q <= B_W'(ref_q) * B_W'(fs_minus);
    end
  end

  // log2 of both resistances
  logic [X_W-1:0]  log_x [2];
  logic [LQ_W-1:0] log_y [2];
  ntc_pkg::side_t  lg_side;

  assign log_x[0] = X_W'(a_q);
  assign log_x[1] = X_W'(b_q);

  ntc_log2 #(
    .X_W (X_W)
  ) u_log2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .side_i (s0_side_q),
    .x_i    (log_x),
    .side_o (lg_side),
    .log_o  (log_y)
  );

  // stage 1: log2 difference as sign and magnitude
  logic signed [D_W-1:0] d;
  ntc_pkg::side_t        s1_side_q;
  logic [LQ_W-1:0]       mag_q;
  logic                  neg1_q;

  assign d = signed'({1'b0, log_y[0]}) - signed'({1'b0, log_y[1]});

  // stage 2: ln = round(|d| * ln2)
  logic [LP_W-1:0]  lnp;
  ntc_pkg::side_t   s2_side_q;
  logic [LQ_W-1:0]  ln_q;
  logic             neg2_q;

  assign lnp = LP_W'(mag_q) * LP_W'(ntc_pkg::LN2_Q30) + (LP_W'(1) << (LN2_W - 1));

  // stage 3: t0 * ln, signed
  logic [TL_W-1:0]           tl;
  logic signed [DEN_SW-1:0]  tln_d;
  ntc_pkg::side_t            s3_side_q;
  logic signed [DEN_SW-1:0]  tln_q;

  assign tl    = TL_W'(t0_q) * TL_W'(ln_q);
  assign tln_d = neg2_q ? -signed'(DEN_SW'(tl)) : signed'(DEN_SW'(tl));

  // stage 4: denominator beta*2^24 + t0*ln and its sign
  logic signed [DEN_SW-1:0]  den_d;
  ntc_pkg::side_t            s4_side_d, s4_side_q;
  logic [DEN_W-1:0]          den_q;

  assign den_d = signed'(DEN_SW'({beta_q, {FRAC_W{1'b0}}})) + tln_q;

  always_comb begin
    s4_side_d     = s3_side_q;
    s4_side_d.hot = den_d[DEN_SW-1] || (den_d == '0);
  end

  // stage 5: rounded numerator
  ntc_pkg::side_t    s5_side_q;
  logic [NP_W-1:0]   np_q;
  logic [DEN_W-1:0]  den5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_side_q <= '0;
      s2_side_q <= '0;
      s3_side_q <= '0;
      s4_side_q <= '0;
      s5_side_q <= '0;
    end else if (en) begin
      s1_side_q <= lg_side;
      s2_side_q <= s1_side_q;
      s3_side_q <= s2_side_q;
      s4_side_q <= s4_side_d;
      s5_side_q <= s4_side_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      neg1_q <= d[D_W-1];
      mag_q  <= d[D_W-1] ? LQ_W'(-d) : LQ_W'(d);
      neg2_q <= neg1_q;
      ln_q   <= lnp[LP_W-1 -: LQ_W];
      tln_q  <= tln_d;
      den_q  <= den_d[DEN_W-1:0];
      np_q   <= NP_W'({numc_q, {FRAC_W{1'b0}}}) + NP_W'(den_q[DEN_W-1:1]);
      den5_q <= den_q;
    end
  end

  // kelvin quotient
  ntc_pkg::side_t   dv_side;
  logic [TK_W-1:0]  tk;
  logic             tk_ovf;

  ntc_div #(
    .NP_W  (NP_W),
    .DEN_W (DEN_W),
    .Q_W   (TK_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .side_i (s5_side_q),
    .num_i  (np_q),
    .den_i  (den5_q),
    .side_o (dv_side),
    .quo_o  (tk),
    .ovf_o  (tk_ovf)
  );

  // final stage: offset, celsius shift, saturation and status
  logic signed [RES_W-1:0]  r;
  logic signed [TEMP_W-1:0] fin_temp_d, fin_temp_q;
  ntc_pkg::status_e         fin_st_d, fin_st_q;

  assign r = signed'(RES_W'(tk)) + RES_W'(offs_q) - ntc_pkg::CELSIUS_CENTI;

  always_comb begin
    fin_temp_d = '0;
    fin_st_d   = dv_side.st;
    if (dv_side.st == ntc_pkg::ST_OK) begin
      if (dv_side.hot || tk_ovf || r > ntc_pkg::OUT_MAX) begin
        fin_temp_d = OUT_MAX_T;
        fin_st_d   = ntc_pkg::ST_SAT;
      end else if (r < ntc_pkg::OUT_MIN) begin
        fin_temp_d = OUT_MIN_T;
        fin_st_d   = ntc_pkg::ST_SAT;
      end else begin
        fin_temp_d = TEMP_W'(r);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_side_q <= '0;
    end else if (en) begin
      fin_side_q <= dv_side;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fin_temp_q <= fin_temp_d;
      fin_st_q   <= fin_st_d;
    end
  end

  // output register, refilled whenever it is empty or being taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || temp_o.ready) begin
      out_vld_q <= fin_side_q.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || temp_o.ready) begin
      out_q.temperature_centi <= fin_temp_q;
      out_q.status            <= fin_st_q;
    end
  end

  assign temp_o.valid = out_vld_q;
  assign temp_o.data  = out_q;

  // checks
  `NTC_ASSERT_NEVER(a_flag_temp_zero, clk_i, rst_ni, temp_o.valid && (temp_o.data.status == ntc_pkg::ST_ZERO || temp_o.data.status == ntc_pkg::ST_FULL) && temp_o.data.temperature_centi != '0)
  `NTC_ASSERT(a_sat_at_limit, clk_i, rst_ni, temp_o.valid && temp_o.data.status == ntc_pkg::ST_SAT |-> temp_o.data.temperature_centi == OUT_MAX_T || temp_o.data.temperature_centi == OUT_MIN_T)
  `NTC_ASSERT(a_ok_in_range, clk_i, rst_ni, temp_o.valid && temp_o.data.status == ntc_pkg::ST_OK |-> temp_o.data.temperature_centi <= OUT_MAX_T && temp_o.data.temperature_centi >= OUT_MIN_T)

endmodule

>>> bench/tb_ntc_adc_to_temperature.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ntc_adc_to_temperature
// self-checking bench for the ntc adc code to temperature converter: a
// fixed-point beta-equation predictor feeds a scoreboard, random stalls on
// both channels, register settings swept between phases
// ----------------------------------------------------------------------------
module tb_ntc_adc_to_temperature;

  localparam int unsigned FS = ntc_pkg::ADC_FULL_SCALE;
  localparam int LATENCY = 53;
  localparam int WATCHDOG_LIMIT = 2000;

  // scoreboard with the converter's own predictor and settings
  class temp_scoreboard;
    int unsigned beta, series, refohm, t0;
    int offs;
    ntc_pkg::out_t pending[$];
    int mismatches, checked, sat_seen, zero_seen, full_seen;

    function new();
      beta = ntc_pkg::RST_BETA; series = ntc_pkg::RST_SERIES;
      refohm = ntc_pkg::RST_REF; t0 = ntc_pkg::RST_T0;
      offs = ntc_pkg::RST_OFFSET;
    endfunction

    function void set_reg(ntc_pkg::cfg_idx_e idx, logic [ntc_pkg::CFG_DATA_W-1:0] v);
      case (idx)
        ntc_pkg::CFG_BETA:       beta = v[ntc_pkg::BETA_W-1:0];
        ntc_pkg::CFG_SERIES:     series = v[ntc_pkg::OHMS_W-1:0];
        ntc_pkg::CFG_REF_OHMS:   refohm = v[ntc_pkg::OHMS_W-1:0];
        ntc_pkg::CFG_REF_KELVIN: t0 = v[ntc_pkg::T0_W-1:0];
        ntc_pkg::CFG_OFFSET:     offs = $signed(v[ntc_pkg::OFFS_W-1:0]);
        default: ;
      endcase
    endfunction

    // log2 in q24 of a positive integer
    function longint unsigned log2q24(longint unsigned x);
      int n;
      longint unsigned y, f;
      n = 63;
      f = 0;
      while (n > 0 && x[n] == 1'b0) n--;
      y = (n >= 31) ? (x >> (n - 31)) : (x << (31 - n));
      for (int i = 0; i < 24; i++) begin
        y = (y * y) >> 31;
        f = f << 1;
        if (y >= 64'h1_0000_0000) begin
          f = f | 1;
          y = y >> 1;
        end
      end
      return (longint'(n) << 24) | f;
    endfunction

    function ntc_pkg::out_t convert(logic [ntc_pkg::CODE_W-1:0] code);
      ntc_pkg::out_t o;
      longint d, lnv, den, r;
      longint unsigned mag, lnmag, num, tk;
      o.temperature_centi = '0;
      o.status = ntc_pkg::ST_OK;
      if (code == 0 || series == 0) o.status = ntc_pkg::ST_ZERO;
      else if (code >= FS || refohm == 0) o.status = ntc_pkg::ST_FULL;
      else begin
        d = longint'(log2q24(longint'(series) * code))
          - longint'(log2q24(longint'(refohm) * (FS - code)));
        mag = (d < 0) ? -d : d;
        lnmag = (mag * 64'd744261118 + (64'd1 << 29)) >> 30;
        lnv = (d < 0) ? -longint'(lnmag) : longint'(lnmag);
        den = (longint'(beta) << 24) + longint'(t0) * lnv;
        if (den <= 0) begin
          o.temperature_centi = ntc_pkg::TEMP_W'(80000);
          o.status = ntc_pkg::ST_SAT;
        end else begin
          num = (64'd100 * beta * t0) << 24;
          tk = (num + longint'(den) / 2) / longint'(den);
          r = longint'(tk) + offs - 27300;
          if (r > 80000) begin
            o.temperature_centi = ntc_pkg::TEMP_W'(80000); o.status = ntc_pkg::ST_SAT;
          end else if (r < -30000) begin
            o.temperature_centi = ntc_pkg::TEMP_W'(-30000); o.status = ntc_pkg::ST_SAT;
          end else o.temperature_centi = ntc_pkg::TEMP_W'(r);
        end
      end
      return o;
    endfunction

    function void note_code(logic [ntc_pkg::CODE_W-1:0] code);
      pending.push_back(convert(code));
    endfunction

    function void check_result(ntc_pkg::out_t got);
      ntc_pkg::out_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d status %0d",
          got.temperature_centi, got.status);
        return;
      end
      exp_r = pending.pop_front();
      checked++;
      if (exp_r.status == ntc_pkg::ST_SAT) sat_seen++;
      if (exp_r.status == ntc_pkg::ST_ZERO) zero_seen++;
      if (exp_r.status == ntc_pkg::ST_FULL) full_seen++;
      if (got.temperature_centi !== exp_r.temperature_centi
          || got.status !== exp_r.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected temp %0d status %0d, got temp %0d status %0d",
            exp_r.temperature_centi, exp_r.status, got.temperature_centi, got.status);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [ntc_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [ntc_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;
  int idle_cycles = 0;
  logic timed_out = 1'b0;
  temp_scoreboard sb = new();

  ntc_stream_if #(.payload_t(ntc_pkg::in_t))  adc_ch ();
  ntc_stream_if #(.payload_t(ntc_pkg::out_t)) temp_ch ();

  ntc_adc_to_temperature dut (
    .clk_i, .rst_ni, .adc_i(adc_ch), .temp_o(temp_ch),
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  always #5 clk_i = ~clk_i;

  initial begin
    adc_ch.valid = 1'b0;
    adc_ch.data = '0;
    temp_ch.ready = 1'b0;
  end

  // transaction monitor on both channels plus watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (adc_ch.valid && adc_ch.ready) sb.note_code(adc_ch.data.adc_code);
      if (temp_ch.valid && temp_ch.ready) sb.check_result(temp_ch.data);
      if ((adc_ch.valid && adc_ch.ready) || (temp_ch.valid && temp_ch.ready))
        idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
        timed_out = 1'b1;
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // result side: random stalls, with some stretches of no stalling
  initial begin
    int gap;
    wait (rst_ni);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        temp_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      temp_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!temp_ch.valid) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  int burst_mode = 0;

  task automatic send_code(logic [ntc_pkg::CODE_W-1:0] code);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      adc_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    adc_ch.valid <= 1'b1;
    adc_ch.data.adc_code <= code;
    @(posedge clk_i);
    while (!adc_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    adc_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 5) @(negedge clk_i);
  endtask

  // one register write, with the write enable low again before the task returns
  task automatic write_reg(ntc_pkg::cfg_idx_e idx, int unsigned v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= ntc_pkg::CFG_DATA_W'(v);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, ntc_pkg::CFG_DATA_W'(v));
    @(negedge clk_i);
  endtask

  task automatic load_settings(int unsigned b, int unsigned s, int unsigned r,
                               int unsigned t, int o);
    write_reg(ntc_pkg::CFG_BETA, b);
    write_reg(ntc_pkg::CFG_SERIES, s);
    write_reg(ntc_pkg::CFG_REF_OHMS, r);
    write_reg(ntc_pkg::CFG_REF_KELVIN, t);
    write_reg(ntc_pkg::CFG_OFFSET, o & 16'h7fff);
  endtask

  // mostly codes in the useful middle band, some near either end, some anywhere
  function automatic logic [ntc_pkg::CODE_W-1:0] rand_code();
    case ($urandom_range(0, 9))
      0: return ntc_pkg::CODE_W'($urandom_range(0, 15));
      1: return ntc_pkg::CODE_W'($urandom_range(4080, 4095));
      2, 3: return ntc_pkg::CODE_W'($urandom());
      default: return ntc_pkg::CODE_W'($urandom_range(300, 3800));
    endcase
  endfunction

  initial begin
    logic [ntc_pkg::CODE_W-1:0] directed[$] = '{12'd0, 12'd1, 12'd2, 12'd4095,
      12'd4094, 12'd2048, 12'd2047, 12'd1024, 12'd3072, 12'hAAA, 12'h555, 12'd100,
      12'd4000, 12'd400, 12'd3900, 12'd800};
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // defaults after reset
    foreach (directed[i]) send_code(directed[i]);
    drain();

    // extreme settings, the first two each followed by a directed pass, the others by spot codes
    load_settings(1000, 100, 1000000, 200, -10000);
    foreach (directed[i]) send_code(directed[i]);
    drain();
    load_settings(10000, 1000000, 100, 400, 10000);
    foreach (directed[i]) send_code(directed[i]);
    drain();
    load_settings(16383, 0, 10000, 298, 0);
    send_code(12'd2000); send_code(12'd0);
    drain();
    load_settings(4030, 10000, 0, 0, 16383);
    send_code(12'd2000); send_code(12'd4095); send_code(12'd1);
    drain();

    // random phases across settings
    for (int ph = 0; ph < 16; ph++) begin
      if (ph == 0) load_settings(ntc_pkg::RST_BETA, ntc_pkg::RST_SERIES, ntc_pkg::RST_REF,
        ntc_pkg::RST_T0, -500);
      else load_settings($urandom_range(1000, 10000), $urandom_range(100, 1000000),
        $urandom_range(100, 1000000), $urandom_range(200, 400),
        int'($urandom_range(0, 20000)) - 10000);
      if (ph % 5 == 4) write_reg(ntc_pkg::CFG_OFFSET, $urandom_range(0, 32767));
      for (int k = 0; k < 100; k++) begin
        if (k % 25 == 0) burst_mode = ($urandom_range(0, 2) == 0);
        send_code(rand_code());
      end
      burst_mode = 0;
      drain();
    end

    if (sb.mismatches == 0 && !timed_out) begin
      $display("checked %0d results: %0d code zero, %0d full scale, %0d saturated",
        sb.checked, sb.zero_seen, sb.full_seen, sb.sat_seen);
      $display("register sweeps covered defaults, extremes and random settings");
      $display("TEST PASSED");
    end else begin
      $display("checked %0d results, %0d mismatches", sb.checked, sb.mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

>>> filelist.f
+incdir+rtl
rtl/ntc_pkg.sv
rtl/ntc_stream_if.sv
rtl/ntc_log2.sv
rtl/ntc_div.sv
rtl/ntc_adc_to_temperature.sv
bench/tb_ntc_adc_to_temperature.sv
